// ----- rtl/core/msdl_pkg.sv -----
`timescale 1ns / 1ps
// msdl_pkg: types, constants and helper functions for the microphone sample
// despike and level block. No dependencies.
package msdl_pkg;

    localparam int SLOT_W     = 32;
    localparam int PCM_W      = 16;
    localparam int SUM_W      = 28;
    localparam int FL_W       = 13;
    localparam int THR_W      = 17;
    localparam int CFG_W      = 17;
    localparam int CFG_IDX_W  = 1;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_THRESHOLD = 1'd1;

    localparam logic [FL_W-1:0]  FRAME_LENGTH_RST = 13'd320;
    localparam logic [THR_W-1:0] SILENCE_THR_RST  = 17'd0;

    localparam logic [PCM_W-1:0] SPIKE_LEVEL = 16'd20000;
    localparam logic [PCM_W-1:0] QUIET_LEVEL = 16'd500;

    typedef struct packed {
        logic signed [SLOT_W-1:0] raw_slot;
        logic                     end_of_read;
    } t_in;

    typedef struct packed {
        logic signed [PCM_W-1:0] pcm_sample;
        logic                    last_of_frame;
        logic [SUM_W-1:0]        frame_level_sum;
        logic                    silent;
    } t_out;

    // up to two results handed to the output queue in one cycle, in order
    typedef struct packed {
        logic [1:0] count;
        t_out       first;
        t_out       second;
    } t_push;

    function automatic logic [PCM_W-1:0] mag16(input logic signed [PCM_W-1:0] v);
        logic [PCM_W-1:0] r;
        r = v[PCM_W-1] ? PCM_W'(-v) : PCM_W'(v);
        return r;
    endfunction

    // saturating level accumulate
    function automatic logic [SUM_W-1:0] sum_sat(input logic [SUM_W-1:0] a,
                                                 input logic [PCM_W-1:0] m);
        logic [SUM_W:0] t;
        t = {1'b0, a} + (SUM_W+1)'(m);
        return t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
    endfunction

endpackage

// ----- rtl/core/msdl_out_fifo.sv -----
`timescale 1ns / 1ps
// msdl_out_fifo: small result queue, up to two writes and one read per cycle.
// Depends on msdl_pkg.
module msdl_out_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  msdl_pkg::t_push i_push,
    output logic           o_room2,
    output logic           o_valid,
    input  logic           i_ready,
    output msdl_pkg::t_out o_data
);

    msdl_pkg::t_out                   r_mem [msdl_pkg::FIFO_DEPTH];
    logic [msdl_pkg::FIFO_AW-1:0]     r_wp;
    logic [msdl_pkg::FIFO_AW-1:0]     r_rp;
    logic [msdl_pkg::FIFO_CW-1:0]     r_count;
    logic [msdl_pkg::FIFO_AW-1:0]     n_wp;
    logic [msdl_pkg::FIFO_AW-1:0]     n_rp;
    logic [msdl_pkg::FIFO_CW-1:0]     n_count;
    logic [msdl_pkg::FIFO_AW-1:0]     wp1;
    logic                             pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rp];
    assign o_room2 = (r_count <= msdl_pkg::FIFO_CW'(msdl_pkg::FIFO_DEPTH - 2));
    assign pop     = o_valid && i_ready;
    assign wp1     = r_wp + 1'b1;

    always_comb begin
        n_wp    = r_wp + msdl_pkg::FIFO_AW'(i_push.count);
        n_rp    = pop ? r_rp + 1'b1 : r_rp;
        n_count = r_count + msdl_pkg::FIFO_CW'(i_push.count)
                  - msdl_pkg::FIFO_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wp] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wp1] <= i_push.second;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= msdl_pkg::FIFO_CW'(msdl_pkg::FIFO_DEPTH))
        else $error("result queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |->
            (r_count <= msdl_pkg::FIFO_CW'(msdl_pkg::FIFO_DEPTH) -
                        msdl_pkg::FIFO_CW'(i_push.count)))
        else $error("result queue written without room");

    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_push.count == 2'd0) |=> (r_count == $past(r_count) - 1'b1))
        else $error("result queue count not decremented on read");

endmodule

// ----- rtl/core/msdl_frame.sv -----
`timescale 1ns / 1ps
// msdl_frame: slot to PCM conversion, three-sample spike filter, frame
// position and level sum, registered result pair. Depends on msdl_pkg.
module msdl_frame #(
    parameter int MAX_FRAME = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  msdl_pkg::t_in                   i_in_data,
    input  logic [msdl_pkg::FL_W-1:0]       i_frame_length,
    input  logic [msdl_pkg::THR_W-1:0]      i_silence_threshold,
    input  logic                            i_room2,
    output msdl_pkg::t_push                 o_push
);

    localparam int PW  = $clog2(MAX_FRAME + 1);
    localparam int LW  = (PW > msdl_pkg::FL_W) ? PW : msdl_pkg::FL_W;
    localparam int PRW = msdl_pkg::THR_W + PW;
    localparam int CW  = (PRW > msdl_pkg::SUM_W + 1) ? PRW : msdl_pkg::SUM_W + 1;

    // frame state
    logic signed [msdl_pkg::PCM_W-1:0] r_held;
    logic                              r_held_valid;
    logic signed [msdl_pkg::PCM_W-1:0] r_prev;
    logic [PW-1:0]                     r_pos;
    logic [msdl_pkg::SUM_W-1:0]        r_sum;

    // result stage
    logic                              r_st_valid;
    logic                              r_st_v0;
    logic                              r_st_v1;
    logic signed [msdl_pkg::PCM_W-1:0] r_st_s0;
    logic signed [msdl_pkg::PCM_W-1:0] r_st_s1;
    logic [msdl_pkg::SUM_W-1:0]        r_st_sum;
    logic [PRW-1:0]                    r_st_prod;

    logic signed [msdl_pkg::PCM_W-1:0] n_held;
    logic                              n_held_valid;
    logic signed [msdl_pkg::PCM_W-1:0] n_prev;
    logic [PW-1:0]                     n_pos;
    logic [msdl_pkg::SUM_W-1:0]        n_sum;

    logic                              in_fire;
    logic                              st_take;
    logic signed [msdl_pkg::PCM_W-1:0] s;
    logic signed [msdl_pkg::PCM_W-1:0] v;
    logic                              spike;
    logic [msdl_pkg::SUM_W-1:0]        sum1;
    logic [msdl_pkg::SUM_W-1:0]        sum2;
    logic [PW-1:0]                     pos_new;
    logic [LW-1:0]                     fl_ext;
    logic [LW-1:0]                     len;
    logic                              last;
    logic [PRW-1:0]                    prod;
    logic                              silent;
    msdl_pkg::t_out                    item0;
    msdl_pkg::t_out                    item1;

    assign st_take    = r_st_valid && i_room2;
    assign o_in_ready = !r_st_valid || i_room2;
    assign in_fire    = i_in_valid && o_in_ready;

    assign s = i_in_data.raw_slot[msdl_pkg::SLOT_W-1 -: msdl_pkg::PCM_W];

    always_comb begin
        fl_ext = LW'(i_frame_length);
        if (i_frame_length == '0) begin
            len = LW'(1);
        end else if (fl_ext > LW'(MAX_FRAME)) begin
            len = LW'(MAX_FRAME);
        end else begin
            len = fl_ext;
        end
    end

    // inner spike: loud sample between two quiet ones, output as zero
    assign spike = (r_pos >= PW'(2))
                && (msdl_pkg::mag16(r_held) > msdl_pkg::SPIKE_LEVEL)
                && (msdl_pkg::mag16(r_prev) < msdl_pkg::QUIET_LEVEL)
                && (msdl_pkg::mag16(s) < msdl_pkg::QUIET_LEVEL);
    assign v       = spike ? '0 : r_held;
    assign sum1    = r_held_valid ? msdl_pkg::sum_sat(r_sum, msdl_pkg::mag16(v)) : r_sum;
    assign sum2    = msdl_pkg::sum_sat(sum1, msdl_pkg::mag16(s));
    assign pos_new = r_pos + 1'b1;
    assign last    = i_in_data.end_of_read || (LW'(pos_new) >= len);
    assign prod    = PRW'(i_silence_threshold) * PRW'(pos_new);

    always_comb begin
        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_prev       = r_prev;
        n_pos        = r_pos;
        n_sum        = r_sum;
        if (in_fire) begin
            if (last) begin
                n_held       = '0;
                n_held_valid = 1'b0;
                n_prev       = '0;
                n_pos        = '0;
                n_sum        = '0;
            end else begin
                n_held       = s;
                n_held_valid = 1'b1;
                n_prev       = r_held_valid ? v : r_prev;
                n_pos        = pos_new;
                n_sum        = sum1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held       <= '0;
            r_held_valid <= 1'b0;
            r_prev       <= '0;
            r_pos        <= '0;
            r_sum        <= '0;
            r_st_valid   <= 1'b0;
        end else begin
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
            r_prev       <= n_prev;
            r_pos        <= n_pos;
            r_sum        <= n_sum;
            if (in_fire) begin
                r_st_valid <= r_held_valid || last;
            end else if (st_take) begin
                r_st_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_st_v0   <= r_held_valid;
            r_st_v1   <= last;
            r_st_s0   <= v;
            r_st_s1   <= s;
            r_st_sum  <= sum2;
            r_st_prod <= prod;
        end
    end

    assign silent = (CW'({r_st_sum, 1'b0}) < CW'(r_st_prod));

    always_comb begin
        item0.pcm_sample      = r_st_s0;
        item0.last_of_frame   = 1'b0;
        item0.frame_level_sum = '0;
        item0.silent          = 1'b0;
        item1.pcm_sample      = r_st_s1;
        item1.last_of_frame   = 1'b1;
        item1.frame_level_sum = r_st_sum;
        item1.silent          = silent;
        o_push.first          = r_st_v0 ? item0 : item1;
        o_push.second         = item1;
        o_push.count          = st_take ? (2'(r_st_v0) + 2'(r_st_v1)) : 2'd0;
    end

    a_stage_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st_valid |-> (r_st_v0 || r_st_v1))
        else $error("result stage valid with no result");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && last) |=> (!r_held_valid && r_pos == '0 && r_sum == '0))
        else $error("frame state not cleared after last sample");

    a_held_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_valid |-> (r_pos != '0))
        else $error("held sample without frame position");

endmodule

// ----- rtl/core/mic_sample_despike_level_top.sv -----
`timescale 1ns / 1ps
// mic_sample_despike_level_top: configuration registers, frame filter and
// result queue. Depends on msdl_pkg, msdl_frame, msdl_out_fifo.
//
//  port group     direction  handshake              payload
//  i_in_*         in         i_in_valid/o_in_ready  msdl_pkg::t_in
//  o_out_*        out        o_out_valid/i_out_ready msdl_pkg::t_out
//  i_cfg_*        in         i_cfg_we only          index + 17-bit data
//
// One slot accepted per cycle unless a stalled output holds slots off; each slot yields zero, one or two results.
// A result passes through the result stage, then the four-entry queue; the
// one-result-per-cycle output port sets the sustained rate of one slot per
// cycle.
// Reset is synchronous; it empties the queue and restarts the frame.
// A stalled output holds slots off while the result stage is full and the
// queue has fewer than two free entries.
module mic_sample_despike_level_top #(
    parameter int MAX_FRAME = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  msdl_pkg::t_in                       i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output msdl_pkg::t_out                      o_out_data,
    input  logic                                i_cfg_we,
    input  logic [msdl_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [msdl_pkg::CFG_W-1:0]          i_cfg_data
);

    logic [msdl_pkg::FL_W-1:0]  r_frame_length;
    logic [msdl_pkg::THR_W-1:0] r_silence_threshold;
    msdl_pkg::t_push            push;
    logic                       room2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_length      <= msdl_pkg::FRAME_LENGTH_RST;
            r_silence_threshold <= msdl_pkg::SILENCE_THR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                msdl_pkg::CFG_FRAME_LENGTH: begin
                    r_frame_length <= i_cfg_data[msdl_pkg::FL_W-1:0];
                end
                msdl_pkg::CFG_SILENCE_THRESHOLD: begin
                    r_silence_threshold <= i_cfg_data[msdl_pkg::THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    msdl_frame #(
        .MAX_FRAME (MAX_FRAME)
    ) u_frame (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_in_data           (i_in_data),
        .i_frame_length      (r_frame_length),
        .i_silence_threshold (r_silence_threshold),
        .i_room2             (room2),
        .o_push              (push)
    );

    msdl_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room2 (room2),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule
